// ===== hw/rtl/hrp_pkg.sv =====
// Shared types and constants for the HTTP request header parser.
package hrp_pkg;

   localparam int DATA_W     = 8;
   localparam int ADDR_W     = 6;
   localparam int LEN_W      = 6;
   localparam int TICK_W     = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;
   localparam int MEM_ADDR_W = 8;

   localparam logic [DATA_W-1:0] CH_SPACE = 8'h20;
   localparam logic [DATA_W-1:0] CH_LF    = 8'h0a;
   localparam logic [DATA_W-1:0] CH_CR    = 8'h0d;

   localparam int WS_PREFIX_LEN = 5;
   localparam logic [DATA_W-1:0] WS_PREFIX [WS_PREFIX_LEN] =
      '{8'h2f, 8'h64, 8'h2f, 8'h77, 8'h73};

   localparam logic [TICK_W-1:0] TIMEOUT_RESET = 16'd10;

   typedef enum logic [2:0] {
      RQ_DATA  = 3'd0,
      RQ_TICK  = 3'd1,
      RQ_OPEN  = 3'd2,
      RQ_CLOSE = 3'd3,
      RQ_READ  = 3'd4,
      RQ_SENT  = 3'd5
   } req_kind_type;

   typedef enum logic [3:0] {
      ST_IDLE    = 4'd0,
      ST_METHOD  = 4'd1,
      ST_PATH    = 4'd2,
      ST_PROTO   = 4'd3,
      ST_FLAG    = 4'd4,
      ST_INFLAG  = 4'd5,
      ST_READY   = 4'd6,
      ST_WS_SCAN = 4'd7,
      ST_WS_EST  = 4'd8,
      ST_CLOSING = 4'd9
   } state_type;

   typedef enum logic [2:0] {
      EV_NONE    = 3'd0,
      EV_PLAIN   = 3'd1,
      EV_WS      = 3'd2,
      EV_READY   = 3'd3,
      EV_WS_DONE = 3'd4,
      EV_CLOSE   = 3'd5,
      EV_READ    = 3'd6
   } event_type;

   typedef enum logic [1:0] {
      WS_IDLE = 2'd0,
      WS_LF   = 2'd1,
      WS_CR   = 2'd2
   } ws_phase_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PERSIST = 2'd0,
      CSR_TIMEOUT = 2'd1
   } csr_index_type;

   typedef struct packed {
      logic                  mem_we;
      logic [MEM_ADDR_W-1:0] mem_addr;
      logic [DATA_W-1:0]     mem_data;
      logic                  last_we;
      logic [DATA_W-1:0]     last_data;
   } path_wr_type;

endpackage

// ===== hw/rtl/hrp_if.sv =====
// Channel interfaces: request stream, response stream and CSR write port.
interface hrp_req_if import hrp_pkg::*;;
   logic              valid;
   logic              ready;
   logic [2:0]        req_type;
   logic [DATA_W-1:0] data_byte;
   logic [ADDR_W-1:0] path_addr;

   modport source (output valid, req_type, data_byte, path_addr, input ready);
   modport sink   (input valid, req_type, data_byte, path_addr, output ready);
endinterface

interface hrp_rsp_if import hrp_pkg::*;;
   logic              valid;
   logic              ready;
   logic [2:0]        event_res;
   logic [LEN_W-1:0]  path_length;
   logic [DATA_W-1:0] read_data;
   logic [3:0]        conn_state;

   modport source (output valid, event_res, path_length, read_data, conn_state,
                   input ready);
   modport sink   (input valid, event_res, path_length, read_data, conn_state,
                   output ready);
endinterface

interface hrp_csr_if import hrp_pkg::*;;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  reg_index;
   logic [CSR_DATA_W-1:0] wr_data;

   modport source (output valid, reg_index, wr_data, input ready);
   modport sink   (input valid, reg_index, wr_data, output ready);
endinterface

// ===== hw/rtl/hrp_path_mem.sv =====
// Path store: memory with one write and one read port for all but the last position, which is a register.
module hrp_path_mem import hrp_pkg::*; #(
   parameter int PATH_DEPTH = 64
) (
   input  logic              clock,
   input  path_wr_type       wr,
   input  logic              rd_en,
   input  logic              rd_sel,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   localparam int MEM_DEPTH = PATH_DEPTH - 1;
   localparam int MW        = $clog2(MEM_DEPTH);

   logic [DATA_W-1:0] mem [MEM_DEPTH];
   logic [DATA_W-1:0] last_ff;
   logic [DATA_W-1:0] rd_data_ff;
   logic              in_range;
   logic              is_last;

   assign in_range = 32'(rd_addr) < PATH_DEPTH;
   assign is_last  = 32'(rd_addr) == PATH_DEPTH - 1;

   always_ff @(posedge clock) begin
      if (wr.mem_we) begin
         mem[MW'(wr.mem_addr)] <= wr.mem_data;
      end
      if (wr.last_we) begin
         last_ff <= wr.last_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         if (!rd_sel || !in_range) begin
            rd_data_ff <= '0;
         end else if (is_last) begin
            rd_data_ff <= last_ff;
         end else begin
            rd_data_ff <= mem[MW'(rd_addr)];
         end
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/hrp_parser.sv =====
// Connection state machine: method skip, path capture, header and websocket scans, idle timeout.
module hrp_parser import hrp_pkg::*; #(
   parameter int PATH_DEPTH = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic [2:0]        kind,
   input  logic [DATA_W-1:0] data_byte,
   input  logic              persist,
   input  logic [TICK_W-1:0] timeout_limit,
   output event_type         ev,
   output logic [LEN_W-1:0]  path_length,
   output state_type         conn_state,
   output path_wr_type       wr
);

   localparam int IW = $clog2(PATH_DEPTH);
   localparam logic [IW-1:0] IDX_LAST = IW'(PATH_DEPTH - 1);
   localparam logic [IW-1:0] IDX_PRE  = IW'(PATH_DEPTH - 2);

   state_type              state_ff, state_in;
   ws_phase_type           phase_ff, phase_in;
   logic [IW-1:0]          index_ff, index_in;
   logic [TICK_W-1:0]      ticks_ff, ticks_in;
   logic [WS_PREFIX_LEN-1:0] match_ff, match_in;
   req_kind_type           rq;
   logic                   is_space;
   logic                   saturated;
   logic                   expired;
   logic                   counting;
   logic                   ws_path;

   assign rq        = req_kind_type'(kind);
   assign is_space  = data_byte == CH_SPACE;
   assign saturated = index_ff == IDX_LAST;
   assign expired   = ticks_ff > timeout_limit;
   assign counting  = (state_ff == ST_METHOD) || (state_ff == ST_PATH) ||
                      (state_ff == ST_PROTO) || (state_ff == ST_FLAG) ||
                      (state_ff == ST_INFLAG);
   assign ws_path   = (index_ff >= IW'(WS_PREFIX_LEN)) && (&match_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      index_in = index_ff;
      ticks_in = ticks_ff;
      match_in = match_ff;
      case (rq)
         RQ_DATA: begin
            ticks_in = '0;
            case (state_ff)
               ST_METHOD: begin
                  if (is_space) begin
                     state_in = ST_PATH;
                     index_in = '0;
                  end
               end
               ST_PATH: begin
                  for (int i = 0; i < WS_PREFIX_LEN; i++) begin
                     if (index_ff == IW'(i)) begin
                        match_in[i] = data_byte == WS_PREFIX[i];
                     end
                  end
                  if (saturated) begin
                     index_in = is_space ? IDX_PRE : IDX_LAST;
                  end else begin
                     index_in = is_space ? index_ff : index_ff + 1'b1;
                  end
                  if (is_space) begin
                     if (ws_path) begin
                        state_in = ST_WS_SCAN;
                        phase_in = WS_IDLE;
                     end else begin
                        state_in = ST_PROTO;
                     end
                  end
               end
               ST_PROTO: begin
                  if (data_byte == CH_LF) state_in = ST_FLAG;
               end
               ST_FLAG: begin
                  if (data_byte == CH_LF) begin
                     state_in = ST_READY;
                  end else if (data_byte != CH_CR) begin
                     state_in = ST_INFLAG;
                  end
               end
               ST_INFLAG: begin
                  if (data_byte == CH_LF) state_in = ST_FLAG;
               end
               ST_WS_SCAN: begin
                  case (phase_ff)
                     WS_LF: begin
                        phase_in = (data_byte == CH_CR) ? WS_CR : WS_IDLE;
                     end
                     WS_CR: begin
                        phase_in = WS_IDLE;
                        if (data_byte == CH_LF) state_in = ST_WS_EST;
                     end
                     default: begin
                        phase_in = (data_byte == CH_LF) ? WS_LF : WS_IDLE;
                     end
                  endcase
               end
               ST_CLOSING: begin
                  state_in = persist ? ST_METHOD : ST_CLOSING;
               end
               default: ;
            endcase
         end
         RQ_TICK: begin
            if (counting) begin
               if (ticks_ff != '1) ticks_in = ticks_ff + 1'b1;
               if (expired) state_in = ST_CLOSING;
            end
         end
         RQ_OPEN: begin
            if (state_ff == ST_IDLE) begin
               state_in = ST_METHOD;
               ticks_in = '0;
               phase_in = WS_IDLE;
               index_in = '0;
            end
         end
         RQ_CLOSE: begin
            state_in = ST_IDLE;
            phase_in = WS_IDLE;
         end
         RQ_SENT: begin
            if (state_ff == ST_READY || state_ff == ST_CLOSING) begin
               state_in = persist ? ST_METHOD : ST_CLOSING;
            end
         end
         default: ;
      endcase
   end

   // event and path store writes
   always_comb begin
      ev = EV_NONE;
      wr = '0;
      case (rq)
         RQ_DATA: begin
            case (state_ff)
               ST_PATH: begin
                  if (is_space) ev = ws_path ? EV_WS : EV_PLAIN;
                  wr.last_data = data_byte;
                  if (saturated) begin
                     wr.last_we  = 1'b1;
                     wr.mem_we   = is_space;
                     wr.mem_addr = MEM_ADDR_W'(IDX_PRE);
                     wr.mem_data = '0;
                  end else begin
                     wr.mem_we   = 1'b1;
                     wr.mem_addr = MEM_ADDR_W'(index_ff);
                     wr.mem_data = is_space ? '0 : data_byte;
                  end
               end
               ST_FLAG: begin
                  if (data_byte == CH_LF) ev = EV_READY;
               end
               ST_WS_SCAN: begin
                  if (phase_ff == WS_CR && data_byte == CH_LF) ev = EV_WS_DONE;
               end
               ST_CLOSING: begin
                  if (!persist) ev = EV_CLOSE;
               end
               default: ;
            endcase
         end
         RQ_TICK: begin
            if (counting && expired) ev = EV_CLOSE;
         end
         RQ_READ: begin
            ev = EV_READ;
         end
         RQ_SENT: begin
            if ((state_ff == ST_READY || state_ff == ST_CLOSING) && !persist) begin
               ev = EV_CLOSE;
            end
         end
         default: ;
      endcase
      if (!en) wr = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         phase_ff <= WS_IDLE;
         index_ff <= '0;
         ticks_ff <= '0;
         match_ff <= '0;
      end else if (en) begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         index_ff <= index_in;
         ticks_ff <= ticks_in;
         match_ff <= match_in;
      end
   end

   assign path_length = LEN_W'(index_in);
   assign conn_state  = state_in;

endmodule

// ===== hw/rtl/http_request_header_parser_top.sv =====
// Top level: input register, parser, path store, result register and CSRs.
// Accepted requests pass through the input register, then the result register.
// Throughput: one transaction per cycle unless the output stalls; the parser state
// and the path store are updated as a request moves into the result register.
// Reset clears all control state: idle, no connection, keep-alive off, timeout 10.
// The path store is not cleared; its entries are undefined until written.
module http_request_header_parser_top import hrp_pkg::*; #(
   parameter int PATH_DEPTH = 64
) (
   input logic   clock,
   input logic   reset,
   hrp_req_if.sink   req_if,
   hrp_rsp_if.source rsp_if,
   hrp_csr_if.sink   csr_if
);

   logic              s1_valid_ff;
   logic [2:0]        s1_kind_ff;
   logic [DATA_W-1:0] s1_byte_ff;
   logic [ADDR_W-1:0] s1_addr_ff;
   logic              advance;

   logic              rsp_valid_ff;
   event_type         ev_ff;
   logic [LEN_W-1:0]  len_ff;
   state_type         state_ff;

   logic              persist_ff;
   logic [TICK_W-1:0] timeout_ff;

   event_type         ev;
   logic [LEN_W-1:0]  path_length;
   state_type         conn_state;
   path_wr_type       wr;
   logic [DATA_W-1:0] rd_data;

   assign advance      = s1_valid_ff && (!rsp_valid_ff || rsp_if.ready);
   assign req_if.ready = !s1_valid_ff || advance;
   assign csr_if.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         persist_ff <= 1'b0;
         timeout_ff <= TIMEOUT_RESET;
      end else if (csr_if.valid) begin
         case (csr_index_type'(csr_if.reg_index))
            CSR_PERSIST: persist_ff <= csr_if.wr_data[0];
            CSR_TIMEOUT: timeout_ff <= csr_if.wr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_if.ready) begin
         s1_valid_ff <= req_if.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_if.ready && req_if.valid) begin
         s1_kind_ff <= req_if.req_type;
         s1_byte_ff <= req_if.data_byte;
         s1_addr_ff <= req_if.path_addr;
      end
   end

   hrp_parser #(.PATH_DEPTH(PATH_DEPTH)) u_parser (
      .clock         (clock),
      .reset         (reset),
      .en            (advance),
      .kind          (s1_kind_ff),
      .data_byte     (s1_byte_ff),
      .persist       (persist_ff),
      .timeout_limit (timeout_ff),
      .ev            (ev),
      .path_length   (path_length),
      .conn_state    (conn_state),
      .wr            (wr)
   );

   hrp_path_mem #(.PATH_DEPTH(PATH_DEPTH)) u_path_mem (
      .clock   (clock),
      .wr      (wr),
      .rd_en   (advance),
      .rd_sel  (s1_kind_ff == RQ_READ),
      .rd_addr (s1_addr_ff),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         ev_ff    <= ev;
         len_ff   <= path_length;
         state_ff <= conn_state;
      end
   end

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.event_res   = ev_ff;
   assign rsp_if.path_length = len_ff;
   assign rsp_if.read_data   = rd_data;
   assign rsp_if.conn_state  = state_ff;

   a_close_state: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && ev_ff == EV_CLOSE |-> state_ff == ST_CLOSING)
      else $error("close request without close pending state");

   a_ws_state: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (ev_ff == EV_WS) |-> state_ff == ST_WS_SCAN)
      else $error("websocket path done outside websocket scan");

   a_read_only: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rd_data != '0 |-> ev_ff == EV_READ)
      else $error("read data on a non-read transaction");

   a_stall: assert property (@(posedge clock) disable iff (reset)
      !req_if.ready |-> s1_valid_ff && rsp_valid_ff && !rsp_if.ready)
      else $error("input stalled without a full pipeline");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_if.ready |=> rsp_valid_ff && $stable(state_ff))
      else $error("pending result changed while stalled");

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for the HTTP request header parser top level.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import hrp_pkg::*;

   localparam int         PATH_DEPTH   = 64;
   localparam int         CYCLE_LIMIT  = 100000;
   localparam int         DRAIN_CYCLES = 8;
   localparam logic [2:0] RQ_SPARE_6   = 3'd6;
   localparam logic [2:0] RQ_SPARE_7   = 3'd7;
   localparam logic [TICK_W-1:0] TIMEOUT_MAX = 16'hffff;

   typedef struct packed {
      logic [2:0]        kind;
      logic [DATA_W-1:0] data_byte;
      logic [ADDR_W-1:0] path_addr;
   } req_item_type;

   typedef struct packed {
      logic [2:0]        ev;
      logic [LEN_W-1:0]  len;
      logic [DATA_W-1:0] data;
      logic [3:0]        st;
   } reply_type;

   logic clock = 1'b0;
   logic reset;

   hrp_req_if req_ch ();
   hrp_rsp_if rsp_ch ();
   hrp_csr_if csr_ch ();

   http_request_header_parser_top #(
      .PATH_DEPTH(PATH_DEPTH)
   ) i_dut (
      .clock (clock),
      .reset (reset),
      .req_if(req_ch),
      .rsp_if(rsp_ch),
      .csr_if(csr_ch)
   );

   always #5 clock = ~clock;

   // parser state mirror
   state_type         conn_st        = ST_IDLE;
   ws_phase_type      ws_phase       = WS_IDLE;
   int                path_idx       = 0;
   logic [DATA_W-1:0] path_mem [PATH_DEPTH] = '{default: '0};
   bit                path_written [PATH_DEPTH];
   logic [TICK_W-1:0] idle_cnt       = '0;
   logic              persist_cfg    = 1'b0;
   logic [TICK_W-1:0] timeout_cfg    = TIMEOUT_RESET;

   reply_type due_replies [$];
   int        fail_count      = 0;
   int        items_sent      = 0;
   int        idle_pct        = 15;
   int        rsp_hold_cycles = 0;
   int        cycle_count     = 0;

   function automatic event_type respond_done();
      if (persist_cfg) begin
         conn_st = ST_METHOD;
         return EV_NONE;
      end
      conn_st = ST_CLOSING;
      return EV_CLOSE;
   endfunction

   function automatic reply_type compute_reply(req_item_type it);
      event_type         ev;
      logic [DATA_W-1:0] rd;
      logic [DATA_W-1:0] c;
      bit                prefix_ok;
      bit                expired;
      reply_type         r;
      ev = EV_NONE;
      rd = '0;
      c  = it.data_byte;
      case (it.kind)
         RQ_DATA: begin
            idle_cnt = '0;
            case (conn_st)
               ST_METHOD: begin
                  if (c == CH_SPACE) begin
                     conn_st  = ST_PATH;
                     path_idx = 0;
                  end
               end
               ST_PATH: begin
                  if (path_idx >= PATH_DEPTH) path_idx = PATH_DEPTH - 1;
                  path_mem[path_idx]     = c;
                  path_written[path_idx] = 1'b1;
                  path_idx++;
                  if (path_idx >= PATH_DEPTH) path_idx = PATH_DEPTH - 1;
                  if (c == CH_SPACE) begin
                     path_idx--;
                     path_mem[path_idx]     = '0;
                     path_written[path_idx] = 1'b1;
                     prefix_ok = (path_idx >= WS_PREFIX_LEN);
                     for (int i = 0; i < WS_PREFIX_LEN; i++)
                        if (path_mem[i] != WS_PREFIX[i]) prefix_ok = 1'b0;
                     if (prefix_ok) begin
                        conn_st  = ST_WS_SCAN;
                        ws_phase = WS_IDLE;
                        ev       = EV_WS;
                     end else begin
                        conn_st = ST_PROTO;
                        ev      = EV_PLAIN;
                     end
                  end
               end
               ST_PROTO: begin
                  if (c == CH_LF) conn_st = ST_FLAG;
               end
               ST_FLAG: begin
                  if (c == CH_LF) begin
                     conn_st = ST_READY;
                     ev      = EV_READY;
                  end else if (c != CH_CR) begin
                     conn_st = ST_INFLAG;
                  end
               end
               ST_INFLAG: begin
                  if (c == CH_LF) conn_st = ST_FLAG;
               end
               ST_WS_SCAN: begin
                  case (ws_phase)
                     WS_LF: begin
                        ws_phase = (c == CH_CR) ? WS_CR : WS_IDLE;
                     end
                     WS_CR: begin
                        ws_phase = WS_IDLE;
                        if (c == CH_LF) begin
                           conn_st = ST_WS_EST;
                           ev      = EV_WS_DONE;
                        end
                     end
                     default: begin
                        ws_phase = (c == CH_LF) ? WS_LF : WS_IDLE;
                     end
                  endcase
               end
               ST_CLOSING: begin
                  ev = respond_done();
               end
               default: ;
            endcase
         end
         RQ_TICK: begin
            if (conn_st >= ST_METHOD && conn_st <= ST_INFLAG) begin
               expired = (idle_cnt > timeout_cfg);
               if (idle_cnt != TIMEOUT_MAX) idle_cnt++;
               if (expired) begin
                  conn_st = ST_CLOSING;
                  ev      = EV_CLOSE;
               end
            end
         end
         RQ_OPEN: begin
            if (conn_st == ST_IDLE) begin
               conn_st  = ST_METHOD;
               idle_cnt = '0;
               ws_phase = WS_IDLE;
               path_idx = 0;
            end
         end
         RQ_CLOSE: begin
            conn_st  = ST_IDLE;
            ws_phase = WS_IDLE;
         end
         RQ_READ: begin
            rd = path_mem[it.path_addr];
            ev = EV_READ;
         end
         RQ_SENT: begin
            if (conn_st == ST_READY || conn_st == ST_CLOSING) ev = respond_done();
         end
         default: ;
      endcase
      r.ev   = ev;
      r.len  = LEN_W'(path_idx);
      r.data = rd;
      r.st   = conn_st;
      return r;
   endfunction

   function automatic req_item_type make_item(logic [2:0] kind);
      return '{kind, DATA_W'($urandom), ADDR_W'($urandom)};
   endfunction

   function automatic logic [DATA_W-1:0] pick_byte(logic [DATA_W-1:0] avoid);
      logic [DATA_W-1:0] c;
      case ($urandom_range(15))
         0:       c = 8'h00;
         1:       c = 8'hff;
         default: c = DATA_W'($urandom);
      endcase
      if (c == avoid) c = c ^ 8'h01;
      return c;
   endfunction

   function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         fail_count++;
      end
   endfunction

   task automatic send_item(req_item_type it);
      if ($urandom_range(99) < idle_pct) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 2)) @(posedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.req_type  <= it.kind;
      req_ch.data_byte <= it.data_byte;
      req_ch.path_addr <= it.path_addr;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      due_replies.push_back(compute_reply(it));
      items_sent++;
   endtask

   task automatic send_byte(logic [DATA_W-1:0] c);
      req_item_type it;
      it = make_item(RQ_DATA);
      it.data_byte = c;
      send_item(it);
   endtask

   task automatic send_text(string s);
      for (int i = 0; i < s.len(); i++) send_byte(s[i]);
   endtask

   task automatic send_path_read();
      int           start;
      int           addr;
      req_item_type it;
      start = $urandom_range(PATH_DEPTH - 1);
      addr  = -1;
      for (int i = 0; i < PATH_DEPTH; i++)
         if (addr < 0 && path_written[(start + i) % PATH_DEPTH]) addr = (start + i) % PATH_DEPTH;
      if (addr >= 0) begin
         it = make_item(RQ_READ);
         it.path_addr = ADDR_W'(addr);
         send_item(it);
      end
   endtask

   // occasionally slips a tick, spare code, stray response or path read ahead of the byte
   task automatic send_noisy_byte(logic [DATA_W-1:0] c);
      int r;
      r = $urandom_range(99);
      if (r < 5) send_item(make_item(RQ_TICK));
      else if (r < 7) send_item(make_item($urandom_range(1) ? RQ_SPARE_6 : RQ_SPARE_7));
      else if (r == 7) send_item(make_item(RQ_SENT));
      else if (r == 8) send_path_read();
      send_byte(c);
   endtask

   task automatic settle();
      req_ch.valid <= 1'b0;
      while (due_replies.size() != 0) @(posedge clock);
   endtask

   task automatic write_csr(csr_index_type idx, logic [CSR_DATA_W-1:0] value);
      csr_ch.valid     <= 1'b1;
      csr_ch.reg_index <= idx;
      csr_ch.wr_data   <= value;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      case (idx)
         CSR_PERSIST: persist_cfg = value[0];
         CSR_TIMEOUT: timeout_cfg = value;
         default: ;
      endcase
   endtask

   task automatic set_config(logic persist, logic [TICK_W-1:0] limit);
      settle();
      write_csr(CSR_PERSIST, CSR_DATA_W'({$urandom, persist}));
      write_csr(CSR_TIMEOUT, limit);
      csr_ch.valid <= 1'b0;
   endtask

   task automatic run_session();
      int style;
      if (conn_st == ST_IDLE || $urandom_range(9) == 0) send_item(make_item(RQ_OPEN));
      repeat ($urandom_range(0, 5)) send_noisy_byte(pick_byte(CH_SPACE));
      send_noisy_byte(CH_SPACE);
      if ($urandom_range(9) == 0) repeat ($urandom_range(1, 20)) send_item(make_item(RQ_TICK));
      style = $urandom_range(9);
      if (style < 4) begin
         send_text("/d/ws");
         repeat ($urandom_range(0, 3)) send_noisy_byte(pick_byte(CH_SPACE));
      end else if (style == 4) begin
         send_text("/d/w");
      end else if (style == 5) begin
         repeat ($urandom_range(60, 72)) send_noisy_byte(pick_byte(CH_SPACE));
      end else if (style < 9) begin
         send_text("/");
         repeat ($urandom_range(0, 8)) send_noisy_byte(pick_byte(CH_SPACE));
      end
      send_noisy_byte(CH_SPACE);
      if ($urandom_range(9) == 0) repeat ($urandom_range(1, 20)) send_item(make_item(RQ_TICK));
      if (conn_st == ST_WS_SCAN) begin
         repeat ($urandom_range(0, 6)) send_noisy_byte(pick_byte(CH_LF));
         if ($urandom_range(1)) begin
            send_byte(CH_LF);
            send_byte(CH_CR);
            send_byte(pick_byte(CH_LF));
         end
         send_byte(CH_LF);
         send_byte(CH_CR);
         send_byte(CH_LF);
      end else begin
         repeat ($urandom_range(0, 5)) send_noisy_byte(pick_byte(CH_LF));
         send_noisy_byte(CH_LF);
         repeat ($urandom_range(0, 2)) begin
            repeat ($urandom_range(1, 4)) send_noisy_byte(pick_byte(CH_LF));
            send_noisy_byte(CH_LF);
         end
         if ($urandom_range(1)) send_noisy_byte(CH_CR);
         send_noisy_byte(CH_LF);
      end
      repeat ($urandom_range(0, 3)) send_path_read();
      if ($urandom_range(3) != 0) send_item(make_item(RQ_SENT));
      if (conn_st == ST_CLOSING && $urandom_range(1)) send_noisy_byte(pick_byte(CH_SPACE));
      if (conn_st != ST_IDLE && (conn_st == ST_CLOSING || $urandom_range(2) == 0))
         send_item(make_item(RQ_CLOSE));
   endtask

   task automatic run_sessions(int count);
      int goal;
      goal = items_sent + count;
      while (items_sent < goal) run_session();
   endtask

   task automatic test_directed_ws_request();
      req_item_type it;
      set_config(1'b0, TIMEOUT_MAX);
      send_item(make_item(RQ_SPARE_6));
      send_item(make_item(RQ_SPARE_7));
      send_item(make_item(RQ_SENT));
      send_item(make_item(RQ_TICK));
      send_item(make_item(RQ_OPEN));
      send_item(make_item(RQ_OPEN));
      send_byte(8'hff);
      send_byte(CH_SPACE);
      send_text("/d/ws");
      send_byte(CH_SPACE);
      send_byte(CH_LF);
      send_byte(CH_CR);
      send_byte(CH_LF);
      send_byte(8'h00);
      it = make_item(RQ_READ);
      it.path_addr = '0;
      send_item(it);
      it.path_addr = ADDR_W'(WS_PREFIX_LEN);
      send_item(it);
      send_item(make_item(RQ_CLOSE));
   endtask

   task automatic test_timeout_and_close();
      set_config(1'b0, '0);
      send_item(make_item(RQ_OPEN));
      send_item(make_item(RQ_TICK));
      send_item(make_item(RQ_TICK));
      send_byte(pick_byte(CH_SPACE));
      send_item(make_item(RQ_SENT));
      send_item(make_item(RQ_CLOSE));
   endtask

   task automatic test_keep_alive_sessions();
      set_config(1'b1, TICK_W'($urandom_range(0, 15)));
      run_sessions(100);
   endtask

   task automatic test_closing_sessions();
      set_config(1'b0, TICK_W'($urandom_range(0, 15)));
      run_sessions(100);
   endtask

   task automatic test_full_rate();
      idle_pct = 0;
      set_config(1'($urandom_range(1)), TICK_W'($urandom_range(0, 30)));
      run_sessions(100);
      idle_pct = 15;
   endtask

   task automatic test_backpressure();
      set_config(1'b1, TICK_W'($urandom));
      rsp_hold_cycles = 80;
      run_sessions(100);
   endtask

   initial begin
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_hold_cycles > 0) begin
            rsp_ch.ready <= 1'b0;
            rsp_hold_cycles--;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= idle_pct);
         end
      end
   end

   always @(posedge clock) begin : check_replies
      reply_type want;
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready) begin
         if (due_replies.size() == 0) begin
            $display("%0t: unexpected transaction, event %0d state %0d", $time,
                     rsp_ch.event_res, rsp_ch.conn_state);
            fail_count++;
         end else begin
            want = due_replies.pop_front();
            check_field("event_res", want.ev, rsp_ch.event_res);
            check_field("path_length", want.len, rsp_ch.path_length);
            check_field("read_data", want.data, rsp_ch.read_data);
            check_field("conn_state", want.st, rsp_ch.conn_state);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[http_request_header_parser_top] ERROR");
         $finish;
      end
   end

   initial begin
      reset            <= 1'b1;
      req_ch.valid     <= 1'b0;
      req_ch.req_type  <= RQ_DATA;
      req_ch.data_byte <= '0;
      req_ch.path_addr <= '0;
      csr_ch.valid     <= 1'b0;
      csr_ch.reg_index <= CSR_PERSIST;
      csr_ch.wr_data   <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_directed_ws_request();
      test_timeout_and_close();
      test_keep_alive_sessions();
      test_closing_sessions();
      test_full_rate();
      test_backpressure();
      settle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("[http_request_header_parser_top] OK");
      end else begin
         $display("[http_request_header_parser_top] ERROR");
      end
      $finish;
   end

endmodule

// ===== files.f =====
hw/rtl/hrp_pkg.sv
hw/rtl/hrp_if.sv
hw/rtl/hrp_path_mem.sv
hw/rtl/hrp_parser.sv
hw/rtl/http_request_header_parser_top.sv
verif/testbench.sv
